[src/rmts_pkg.sv]
// Shared types and constants for the rate-monotonic tick scheduler.
package rmts_pkg;

	localparam int TIME_W = 10;
	localparam int NUM_W  = 4;
	localparam int IDX_W  = 3;
	localparam int CNT_W  = 4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	// selection token passed down the cell chain
	typedef struct packed {
		logic              vld;
		logic              found;
		logic [TIME_W-1:0] best;
		logic [NUM_W-1:0]  num;
	} tok_t;

	// task entry write
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] budget;
		logic [TIME_W-1:0] period;
	} ld_t;

	// end-of-tick update broadcast
	typedef struct packed {
		logic             go;
		logic             found;
		logic [NUM_W-1:0] num;
	} upd_t;

endpackage

[src/rmts_cell.sv]
// One task entry of the scheduler chain: state, selection stage and tick update.
module rmts_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rmts_pkg::ld_t              ld,
	input  rmts_pkg::upd_t             upd,
	input  logic [rmts_pkg::CNT_W-1:0] count,
	input  rmts_pkg::tok_t             tok_i,
	output rmts_pkg::tok_t             tok_o
);
	import rmts_pkg::*;

	localparam logic [NUM_W-1:0] MY_NUM = NUM_W'(IDX + 1);

	logic [TIME_W-1:0] budget_q;
	logic [TIME_W-1:0] period_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] phase_q;
	logic              vld_q;
	tok_t              tok_q;
	tok_t              tok_d;
	logic              in_use;
	logic              take;
	logic              chosen;
	logic [TIME_W:0]   ph_inc;

	assign in_use = (32'(count) > IDX) && (period_q != '0);
	assign take   = tok_i.vld && in_use && (rem_q != '0) &&
	                (!tok_i.found || (period_q < tok_i.best));
	assign chosen = upd.found && (upd.num == MY_NUM);
	assign ph_inc = {1'b0, phase_q} + (TIME_W+1)'(1);

	always_comb begin
		tok_d = tok_i;
		if (take) begin
			tok_d.found = 1'b1;
			tok_d.best  = period_q;
			tok_d.num   = MY_NUM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
		if (ld.we && (32'(ld.idx) == IDX)) begin
			budget_q <= ld.budget;
			period_q <= ld.period;
			rem_q    <= ld.budget;
			phase_q  <= '0;
		end else if (upd.go) begin
			if (in_use && (ph_inc >= {1'b0, period_q})) begin
				phase_q <= '0;
				rem_q   <= budget_q;
			end else begin
				if (in_use)
					phase_q <= ph_inc[TIME_W-1:0];
				if (chosen)
					rem_q <= rem_q - TIME_W'(1);
			end
		end
	end

	always_comb begin
		tok_o     = tok_q;
		tok_o.vld = vld_q;
	end

endmodule

[src/rate_monotonic_tick_scheduler_unit.sv]
// Top level of the rate-monotonic tick scheduler: control and cell chain.
//
// Input stream (s_*): one transaction per item. tuser is the op: load writes
// one task entry (execution budget, period; remaining budget reloads, phase
// clears) and gives no result; tick runs one scheduling step and gives one
// result on the output stream (m_*): the chosen task number plus one, 0 idle.
// Configuration (cfg_*): task_count, the number of entries scheduled.
// A load is written into its entry on acceptance. A tick walks a selection token
// down the row of MAX_TASKS cells, one cell per cycle, then updates all
// entries in its update step, which raises m_tvalid; the next item is taken
// the cycle after the update. The chain length sets how long the scan takes.
// The output register holds the result while m_tready is low; a following
// tick waits in its update step until that register is free; loads proceed.
// Reset clears control and task_count; table contents are undefined until
// loaded.
module rate_monotonic_tick_scheduler_unit #(
	parameter int MAX_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // task_index[2:0], exec_budget[12:3], task_period[22:13]
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // running_task[3:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);
	import rmts_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] count_q;
	logic [NUM_W-1:0] run_q;
	logic [NUM_W-1:0] res_q;
	logic             found_q;
	logic             m_tvalid_q;
	logic             s_acc;
	logic             upd_fire;
	ld_t              ld;
	upd_t             upd;
	tok_t             chain [MAX_TASKS+1];

	assign s_acc = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_acc && (s_tuser == OP_TICK)) state_d = ST_SCAN;
			ST_SCAN:   if (chain[MAX_TASKS].vld) state_d = ST_UPDATE;
			ST_UPDATE: if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		upd_fire = (state_q == ST_UPDATE) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid)
				count_q <= cfg_data;
			if (upd_fire)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chain[MAX_TASKS].vld) begin
			found_q <= chain[MAX_TASKS].found;
			run_q   <= chain[MAX_TASKS].found ? chain[MAX_TASKS].num : '0;
		end
		if (upd_fire)
			res_q <= run_q;
	end

	assign ld.we     = s_acc && (s_tuser == OP_LOAD);
	assign ld.idx    = s_tdata[2:0];
	assign ld.budget = s_tdata[12:3];
	assign ld.period = s_tdata[22:13];

	assign upd.go    = upd_fire;
	assign upd.found = found_q;
	assign upd.num   = run_q;

	assign chain[0].vld   = s_acc && (s_tuser == OP_TICK);
	assign chain[0].found = 1'b0;
	assign chain[0].best  = '0;
	assign chain[0].num   = '0;

	for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
		rmts_cell #(.IDX(g)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ld    (ld),
			.upd   (upd),
			.count (count_q),
			.tok_i (chain[g]),
			.tok_o (chain[g+1])
		);
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {4'b0, res_q};

`ifndef SYNTH
	a_tok_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain[MAX_TASKS].vld |-> (state_q == ST_SCAN))
		else $error("selection token left chain outside scan");
	a_tick_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == OP_TICK)) |=> (state_q == ST_SCAN))
		else $error("tick did not start a scan");
	a_update_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> m_tvalid)
		else $error("update without result");
`endif

endmodule
